// File: rtl/double_ended_queue_with_search_defines.svh
// Assertion macros for the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DEQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DEQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/deq_pkg.sv
// Package with types and constants of the deque with search.
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_FIND       = 3'd4;
   localparam logic [2:0] OP_READ       = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_MISS  = 2'd3;

   localparam logic signed [31:0] DATA_NEG_ONE = -32'sd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAIT,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
      logic [3:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [1:0]         status;
      logic [3:0]         found_position;
      logic [4:0]         count;
   } rsp_type;

endpackage

// File: rtl/double_ended_queue_with_search.sv
// Top level of the deque with search: sequencer, entry memory, result register.
//
// Usage:
//   The request channel (req_valid, req_stall, req_payload) carries one
//   operation: push front/back, pop front/back, find a value, or read the
//   entry at a position counted from the front. Every request yields
//   exactly one result on the response channel (rsp_valid, rsp_stall,
//   rsp_payload) with data, status, match position and the entry count
//   after the operation.
//   Timing: a request is taken while the sequencer is idle and worked on
//   alone. Push and the failing cases load their result from the execute
//   step; pop and read go through the memory's registered read port and
//   load it from the wait step. Find walks the entries from the front at
//   one memory read per cycle, up to count reads. The next request is taken
//   in the cycle after a result is loaded.
//   Reset clears the front pointer and the count; the memory needs no
//   clearing since only occupied entries are read.
//   A stalled result holds in the output register while the block takes
//   the next request; that request's result waits until the register frees.
module double_ended_queue_with_search #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
   localparam int PW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_payload
);

   logic             out_free;
   logic             rsp_load;
   deq_pkg::rsp_type rsp_result;
   logic             wr_en;
   logic [PW-1:0]    wr_addr;
   logic [31:0]      wr_data;
   logic             rd_en;
   logic [PW-1:0]    rd_addr;
   logic [31:0]      rd_data;

   logic             rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type rsp_payload_ff;

   // the output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   deq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .out_free   (out_free),
      .rsp_load   (rsp_load),
      .rsp_result (rsp_result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   deq_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // hold the result while the receiver stalls, drop it once taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/deq_ram.sv
// Single-port-write, single-port-read entry memory with registered read data.
module deq_ram #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/deq_ctrl.sv
// Sequencer of the deque: ring pointers, memory accesses and result forming.
`include "double_ended_queue_with_search_defines.svh"
module deq_ctrl #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_payload,
   input  logic             out_free,
   output logic             rsp_load,
   output deq_pkg::rsp_type rsp_result,
   output logic             wr_en,
   output logic [PW-1:0]    wr_addr,
   output logic [31:0]      wr_data,
   output logic             rd_en,
   output logic [PW-1:0]    rd_addr,
   input  logic [31:0]      rd_data
);

   localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);
   localparam logic [PW-1:0] DEPTH_M1 = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   deq_pkg::state_type state_ff, state_in;
   logic [PW-1:0]      front_ff, front_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [PW-1:0]      idx_ff, idx_in;
   logic [2:0]         op_ff;
   logic signed [31:0] value_ff;
   logic [3:0]         pos_ff;

   logic [PW-1:0]      front_dec;
   logic [PW-1:0]      front_inc;
   logic               is_full;
   logic               is_empty;
   logic               pos_ok;
   logic               scan_last;
   logic [PW+3:0]      pos_wide;
   logic [PW+3:0]      cnt_wide;
   logic [PW:0]        idx_next_wide;
   logic signed [31:0] res_data;
   logic [1:0]         res_status;
   logic [3:0]         res_fpos;

   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] front,
                                             input logic [PW-1:0] off);
      logic [PW:0] sum;
      sum = {1'b0, front} + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[PW-1:0];
   endfunction

   assign front_dec     = (front_ff == '0) ? DEPTH_M1 : front_ff - 1'b1;
   assign front_inc     = (front_ff == DEPTH_M1) ? '0 : front_ff + 1'b1;
   assign is_full       = (count_ff == DEPTH_C);
   assign is_empty      = (count_ff == '0);
   assign pos_wide      = (PW + 4)'(pos_ff);
   assign cnt_wide      = (PW + 4)'(count_ff);
   assign pos_ok        = (pos_wide < cnt_wide);
   assign idx_next_wide = {1'b0, idx_ff} + 1'b1;
   assign scan_last     = (idx_next_wide == (PW + 1)'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // capture the request on accept
   always_ff @(posedge clock) begin
      if (state_ff == deq_pkg::ST_IDLE && req_valid) begin
         op_ff    <= req_payload.opcode;
         value_ff <= req_payload.value;
         pos_ff   <= req_payload.position;
      end
   end

   always_comb begin
      state_in   = state_ff;
      front_in   = front_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      req_stall  = 1'b1;
      wr_en      = 1'b0;
      wr_addr    = front_ff;
      wr_data    = value_ff;
      rd_en      = 1'b0;
      rd_addr    = front_ff;
      rsp_load   = 1'b0;
      res_data   = '0;
      res_status = deq_pkg::STATUS_OK;
      res_fpos   = '0;
      unique case (state_ff)
         deq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = deq_pkg::ST_EXEC;
            end
         end
         deq_pkg::ST_EXEC: begin
            unique case (op_ff)
               deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = deq_pkg::ST_IDLE;
                     if (is_full) begin
                        res_data   = deq_pkg::DATA_NEG_ONE;
                        res_status = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (op_ff == deq_pkg::OP_PUSH_FRONT) begin
                           front_in = front_dec;
                           wr_addr  = front_dec;
                        end else begin
                           wr_addr = slot_of(front_ff, PW'(count_ff));
                        end
                     end
                  end
               end
               deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                  if (is_empty) begin
                     if (out_free) begin
                        rsp_load   = 1'b1;
                        state_in   = deq_pkg::ST_IDLE;
                        res_data   = deq_pkg::DATA_NEG_ONE;
                        res_status = deq_pkg::STATUS_EMPTY;
                     end
                  end else begin
                     rd_en    = 1'b1;
                     state_in = deq_pkg::ST_WAIT;
                     if (op_ff == deq_pkg::OP_POP_BACK) begin
                        rd_addr = slot_of(front_ff, PW'(count_ff - 1'b1));
                     end
                  end
               end
               deq_pkg::OP_FIND: begin
                  if (is_empty) begin
                     if (out_free) begin
                        rsp_load   = 1'b1;
                        state_in   = deq_pkg::ST_IDLE;
                        res_data   = deq_pkg::DATA_NEG_ONE;
                        res_status = deq_pkg::STATUS_MISS;
                     end
                  end else begin
                     rd_en    = 1'b1;
                     idx_in   = '0;
                     state_in = deq_pkg::ST_SCAN;
                  end
               end
               deq_pkg::OP_READ: begin
                  if (pos_ok) begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_of(front_ff, PW'(pos_ff));
                     state_in = deq_pkg::ST_WAIT;
                  end else if (out_free) begin
                     rsp_load   = 1'b1;
                     state_in   = deq_pkg::ST_IDLE;
                     res_data   = deq_pkg::DATA_NEG_ONE;
                     res_status = deq_pkg::STATUS_MISS;
                  end
               end
               default: begin
                  // unused opcodes: answer ok, leave the store alone
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = deq_pkg::ST_IDLE;
                  end
               end
            endcase
         end
         deq_pkg::ST_WAIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = deq_pkg::ST_IDLE;
               res_data = rd_data;
               if (op_ff == deq_pkg::OP_POP_FRONT) begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end else if (op_ff == deq_pkg::OP_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         deq_pkg::ST_SCAN: begin
            if (rd_data == value_ff) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = deq_pkg::ST_IDLE;
                  res_data = value_ff;
                  res_fpos = 4'(idx_ff);
               end
            end else if (scan_last) begin
               if (out_free) begin
                  rsp_load   = 1'b1;
                  state_in   = deq_pkg::ST_IDLE;
                  res_data   = deq_pkg::DATA_NEG_ONE;
                  res_status = deq_pkg::STATUS_MISS;
               end
            end else begin
               // advance to the next entry from the front
               rd_en   = 1'b1;
               idx_in  = idx_ff + 1'b1;
               rd_addr = slot_of(front_ff, idx_ff + 1'b1);
            end
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_result.data           = res_data;
   assign rsp_result.status         = res_status;
   assign rsp_result.found_position = res_fpos;
   assign rsp_result.count          = 5'(count_in);

   `DEQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C, "count above depth")
   `DEQ_ASSERT_IMPL(a_load_free, clock, reset, rsp_load, out_free, "result loaded while busy")
   `DEQ_ASSERT_NEXT(a_idle_count, clock, reset, state_ff == deq_pkg::ST_IDLE, $stable(count_ff), "count moved on accept")
   `DEQ_ASSERT_IMPL(a_scan_range, clock, reset, state_ff == deq_pkg::ST_SCAN, (PW + 1)'(idx_ff) < (PW + 1)'(count_ff), "scan index past count")

endmodule
